[design/hsa_pkg.sv]
`timescale 1ns / 1ps
// Shared types for the ascending insertion-chain sorter.
// No dependencies; imported by the cell, the top level and the checker.
package hsa_pkg;

  localparam int unsigned KeyWidth = 32;

  typedef logic signed [KeyWidth-1:0] key_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast key into the sorted row
    logic shift;   // move every key one cell toward the head
  } cell_ctrl_t;

endpackage

[design/heap_sort_ascending_core.sv]
`timescale 1ns / 1ps
// Ascending sorter: a row of CAPACITY cells keeps the held keys in order at all times.
// Collect: one key beat per cycle while in_stall is low; the key is broadcast and each
// cell inserts in one step. Drain: the last beat sets the drain flag, which loads the head
// key into the output register and raises out_valid; then one key per cycle while
// out_stall is low. Input stalls from the last beat until the final key is loaded out.
// Reset (rst_n low, synchronous) empties every cell and clears the output valid.
module heap_sort_ascending_core
  import hsa_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  // input channel
  input  logic in_valid,
  output logic in_stall,
  input  key_t in_key_value,
  input  logic in_last_key,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output key_t out_sorted_value,
  output logic out_last_sorted
);

  // Chain taps: each cell's key, valid flag and insertion decision.
  key_t cell_key   [CAPACITY];
  logic cell_valid [CAPACITY];
  logic cell_move  [CAPACITY];

  cell_ctrl_t ctrl;

  logic drain_r;
  logic drain_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  key_t out_key_r;
  logic out_last_r;

  logic in_beat;
  logic out_load;
  logic final_key;

  // Stall input for the whole drain; the output register decouples the final beat.
  assign in_stall = drain_r;
  assign in_beat  = in_valid && !drain_r;

  // During the drain, load the output register whenever it is empty or being taken this cycle.
  assign out_load  = drain_r && (!out_valid_r || !out_stall);
  // The head key is the final one when the cell behind it is empty.
  assign final_key = !cell_valid[1];

  // Drop keys once the tail cell is occupied; the row is full.
  assign ctrl.insert = in_beat && !cell_valid[CAPACITY-1];
  assign ctrl.shift  = out_load;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      key_t p_key;
      logic p_valid;
      logic p_move;
      key_t n_key;
      logic n_valid;

      if (gi == 0) begin : g_head
        assign p_key   = '0;
        assign p_valid = 1'b1;
        assign p_move  = 1'b0;
      end else begin : g_body
        assign p_key   = cell_key[gi-1];
        assign p_valid = cell_valid[gi-1];
        assign p_move  = cell_move[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign n_key   = '0;
        assign n_valid = 1'b0;
      end else begin : g_inner
        assign n_key   = cell_key[gi+1];
        assign n_valid = cell_valid[gi+1];
      end

      hsa_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_key    (in_key_value),
        .prev_key   (p_key),
        .prev_valid (p_valid),
        .prev_move  (p_move),
        .next_key   (n_key),
        .next_valid (n_valid),
        .key        (cell_key[gi]),
        .valid      (cell_valid[gi]),
        .move       (cell_move[gi])
      );
    end
  endgenerate

  // Enter the drain on the last beat; leave it once the final key is loaded out.
  always_comb begin
    drain_nxt = drain_r;
    if (in_beat && in_last_key) begin
      drain_nxt = 1'b1;
    end else if (out_load && final_key) begin
      drain_nxt = 1'b0;
    end
  end

  // Hold a stalled result; drop the valid once it is taken and nothing replaces it.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r  <= cell_key[0];
      out_last_r <= final_key;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_key_r;
  assign out_last_sorted  = out_last_r;

endmodule

[design/hsa_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorting chain: holds one key and its valid flag.
// Depends on hsa_pkg for key_t and cell_ctrl_t.
module hsa_cell
  import hsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  key_t       new_key,
  input  key_t       prev_key,
  input  logic       prev_valid,
  input  logic       prev_move,
  input  key_t       next_key,
  input  logic       next_valid,
  output key_t       key,
  output logic       valid,
  output logic       move
);

  key_t key_r;
  key_t key_nxt;
  logic valid_r;
  logic valid_nxt;

  // An empty cell acts as plus infinity, so the new key lands in front of it.
  assign move = !valid_r || (new_key < key_r);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      key_nxt   = prev_move ? prev_key : (move ? new_key : key_r);
      valid_nxt = valid_r | prev_valid;
    end else if (ctrl.shift) begin
      key_nxt   = next_key;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

[design/hsa_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the ascending sorter, bound to the top level.
// Depends on hsa_pkg for key_t.
module hsa_checker
  import hsa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input key_t in_key_value,
  input logic in_last_key,
  input logic out_valid,
  input logic out_stall,
  input key_t out_sorted_value,
  input logic out_last_sorted
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value)
      && $stable(out_last_sorted))
    else $error("result beat changed while stalled");

  // Back-to-back result beats of one run never descend.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_sorted) ##1 out_valid
      |-> out_sorted_value >= $past(out_sorted_value))
    else $error("sorted run out of order");

  // While a non-final result is pending, the run is still draining.
  a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_sorted |-> in_stall)
    else $error("input open before run finished draining");

  // A last-key beat starts the drain.
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_key |=> in_stall)
    else $error("drain did not start after last key");

endmodule

bind heap_sort_ascending_core hsa_checker u_hsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_key_value     (in_key_value),
  .in_last_key      (in_last_key),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sorted_value (out_sorted_value),
  .out_last_sorted  (out_last_sorted)
);

[test/tb_heap_sort_ascending_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for heap_sort_ascending_core: key runs in, ascending results out.
// Depends on hsa_pkg (key_t) and the core; holds a sorted-list predictor of its own.
module tb_heap_sort_ascending_core;
  import hsa_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam key_t KEY_MIN = {1'b1, {(KeyWidth-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KeyWidth-1){1'b1}}};

  typedef struct {
    key_t value;
    logic last;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  key_t in_key_value = '0;
  logic in_last_key = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  key_t out_sorted_value;
  logic out_last_sorted;

  // Keys of the open run, always kept in ascending order.
  key_t held_keys[$];
  // Sorted results still owed by the core, oldest first.
  sorted_beat_t pending_sorted[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;

  heap_sort_ascending_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key_value(in_key_value),
    .in_last_key(in_last_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sorted_value(out_sorted_value),
    .out_last_sorted(out_last_sorted)
  );

  always #10 clk = ~clk;

  // Update the predictor with one accepted beat: hold the key while there is room,
  // and on the final key of a run release every held key in ascending order.
  task automatic accept_key(input key_t key, input logic last);
    int pos;
    sorted_beat_t beat;
    pos = 0;
    if (held_keys.size() < CAPACITY) begin
      while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
      held_keys.insert(pos, key);
    end
    if (last) begin
      for (int i = 0; i < held_keys.size(); i++) begin
        beat.value = held_keys[i];
        beat.last  = (i == held_keys.size() - 1);
        pending_sorted = {pending_sorted, beat};
      end
      held_keys.delete();
    end
  endtask

  // Drive one key beat from a falling edge; return at the falling edge after acceptance.
  // Insert random idle cycles ahead of the beat; keep valid high across back-to-back beats.
  task automatic send_key(input key_t key, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_key_value <= key;
    in_last_key  <= last;
    do @(posedge clk); while (in_stall);
    accept_key(key, last);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_sorted_drained();
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(negedge clk);
  endtask

  function automatic key_t random_key();
    case ($urandom_range(9))
      6: return key_t'($urandom_range(16)) - key_t'(8);
      7: begin
        case ($urandom_range(3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  // Extremes, sign boundary, single-key run, duplicates, presorted and reversed runs.
  task automatic test_directed_runs();
    send_key(KEY_MIN, 1'b1);
    send_key(KEY_MAX, 1'b1);
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key(key_t'(1), 1'b1);
    send_key(key_t'(7), 1'b0);
    send_key(key_t'(-3), 1'b0);
    send_key(key_t'(7), 1'b0);
    send_key(key_t'(-3), 1'b0);
    send_key(key_t'(7), 1'b1);
    for (int i = 0; i < 5; i++) send_key(key_t'(i * 1000 - 2000), i == 4);
    for (int i = 0; i < 5; i++) send_key(key_t'(2000 - i * 1000), i == 4);
    send_key(key_t'(32'h5555_5555), 1'b0);
    send_key(key_t'(32'hAAAA_AAAA), 1'b1);
    wait_sorted_drained();
  endtask

  // Overfill the store: keys past CAPACITY are dropped, the last one included.
  task automatic test_store_full();
    for (int i = 0; i < CAPACITY + 6; i++) send_key(random_key(), i == CAPACITY + 5);
    wait_sorted_drained();
    // Exactly CAPACITY keys, then a dropped last key that would sort first.
    for (int i = 0; i < CAPACITY; i++) send_key(key_t'($urandom_range(1000)), 1'b0);
    send_key(KEY_MIN, 1'b1);
    wait_sorted_drained();
  endtask

  // Random runs, mostly short, a few long up to full and a few overfull.
  task automatic test_random_runs(input int send_pct, input int recv_pct, input int num_keys);
    int sent;
    int run_len;
    int roll;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < num_keys) begin
      roll = $urandom_range(99);
      if (roll < 70)      run_len = $urandom_range(12, 1);
      else if (roll < 92) run_len = $urandom_range(40, 13);
      else if (roll < 97) run_len = $urandom_range(CAPACITY, 41);
      else                run_len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
      for (int i = 0; i < run_len; i++) send_key(random_key(), i == run_len - 1);
      sent += run_len;
      // Now and then let the whole run drain before the next one starts.
      if ($urandom_range(7) == 0) wait_sorted_drained();
    end
    wait_sorted_drained();
  endtask

  // Receiver: pick a fresh stall decision every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each accepted result beat against the oldest owed result.
  always @(posedge clk) begin
    sorted_beat_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got value %0d last %0b",
                 $time, out_sorted_value, out_last_sorted);
        error_count++;
      end else begin
        owed = pending_sorted.pop_front();
        if (out_sorted_value !== owed.value) begin
          $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                   $time, owed.value, out_sorted_value);
          error_count++;
        end
        if (out_last_sorted !== owed.last) begin
          $display("%0t: last_sorted mismatch: expected %0b, got %0b",
                   $time, owed.last, out_last_sorted);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_runs();
    test_store_full();
    test_random_runs(0, 0, 75);
    test_random_runs(72, 0, 75);
    test_random_runs(0, 72, 75);
    test_random_runs(30, 30, 75);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Hold for the core's pipeline to settle and flush any stray beat.
    repeat (10) @(negedge clk);
    error_count += pending_sorted.size();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Bound the run well past the slowest correct schedule.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
design/hsa_pkg.sv
design/hsa_cell.sv
design/heap_sort_ascending_core.sv
design/hsa_checker.sv
test/tb_heap_sort_ascending_core.sv
